// ----- rtl/hbfu_pkg.sv -----
// hbfu_pkg: shared types and constants for the 2x half-band interpolator
// no dependencies
package hbfu_pkg;
   localparam int COEF_BITS = 24;
   localparam int COEF_FRAC = 23;
   localparam int CFG_BITS = 5;
   localparam logic [CFG_BITS-1:0] HALF_TAPS_RESET = 5'd12;
   localparam logic CMD_COEF = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MAC,
      ST_ACCUM,
      ST_FINISH,
      ST_OUT0,
      ST_OUT1
   } state_type;
endpackage

// ----- rtl/hbfu_if.sv -----
// hbfu_if: request, response and CSR channel interfaces
// depends on nothing
interface hbfu_req_if #(parameter int SAMPLE_BITS = 24);
   logic valid;
   logic ready;
   logic command;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic [3:0] tap_index;
   logic signed [23:0] tap_value;
   modport source (output valid, command, sample_in, tap_index, tap_value, input ready);
   modport sink (input valid, command, sample_in, tap_index, tap_value, output ready);
endinterface

interface hbfu_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic valid;
   logic ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic phase;
   logic last;
   modport source (output valid, sample_out, phase, last, input ready);
   modport sink (input valid, sample_out, phase, last, output ready);
endinterface

interface hbfu_csr_if;
   logic valid;
   logic ready;
   logic [4:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- rtl/halfband_fir_upsampler_2x.sv -----
// Two-times half-band interpolator. Each sample transfer yields two results: the
// filtered even phase, then the input delayed by half_taps-1 samples, half_taps
// being the clamped value. Each folded tap pair is read from history, multiplied
// bit-serially, one coefficient bit per cycle, through a single shift-and-add unit,
// and accumulated; then the delayed tap is read, the sum is saturated and the two
// results are offered in turn, each able to stall on rsp.ready. A new transfer is
// taken only once both results are out. A coefficient transfer gives no result.
// No clearing pass: history and coefficients reset through per-entry valid bits.
module halfband_fir_upsampler_2x
   import hbfu_pkg::*;
#(
   parameter int MAX_HALF_TAPS = 16,
   parameter int HISTORY_DEPTH = 32,
   parameter int SAMPLE_BITS = 24
) (
   input logic clock,
   input logic reset,
   hbfu_req_if.sink req,
   hbfu_rsp_if.source rsp,
   hbfu_csr_if.sink csr
);
   localparam int HW = $clog2(HISTORY_DEPTH);
   localparam int TW = $clog2(MAX_HALF_TAPS);
   localparam int LIM = (MAX_HALF_TAPS < HISTORY_DEPTH/2) ? MAX_HALF_TAPS : HISTORY_DEPTH/2;
   localparam int PW = SAMPLE_BITS + 1;
   localparam int AW = SAMPLE_BITS + COEF_BITS + 1 + $clog2(LIM) + 1;
   localparam int BW = $clog2(COEF_BITS + 1);

   logic [CFG_BITS-1:0] half_ff;
   state_type state_ff, state_in;
   logic [HW-1:0] wp_ff;
   logic signed [SAMPLE_BITS-1:0] hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hvalid_ff;
   logic signed [COEF_BITS-1:0] coef_mem [MAX_HALF_TAPS];
   logic [MAX_HALF_TAPS-1:0] cvalid_ff;

   logic [5:0] h_eff;
   logic [5:0] k_ff, k_in;
   logic [1:0] rd_ff, rd_in;
   logic [HW-1:0] raddr;
   logic signed [SAMPLE_BITS-1:0] rdata_ff, a_ff;
   logic rvalid_ff;
   logic signed [PW-1:0] pair_ff;
   logic [COEF_BITS-1:0] cshift_ff;
   logic [BW-1:0] bit_ff;
   logic signed [PW+COEF_BITS-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [SAMPLE_BITS-1:0] y_ff, d_ff;

   always_comb begin
      h_eff = {1'b0, half_ff};
      if (half_ff == '0) h_eff = 6'd1;
      if (32'(h_eff) > LIM) h_eff = 6'(LIM);
   end

   // history read address: first mirrored pair, then delayed tap
   always_comb begin
      case (rd_ff)
         2'd0: raddr = wp_ff - HW'(k_ff);
         2'd1: raddr = wp_ff - HW'(7'(2*h_eff) - 7'd1 - 7'(k_ff));
         default: raddr = wp_ff - HW'(h_eff - 6'd1);
      endcase
   end

   wire req_fire = req.valid && req.ready;
   wire smp_fire = req_fire && req.command == CMD_SAMPLE;
   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) half_ff <= HALF_TAPS_RESET;
      else if (csr.valid) half_ff <= csr.data;
   end

   always_ff @(posedge clock) begin
      if (req_fire && req.command == CMD_COEF && 32'(req.tap_index) < MAX_HALF_TAPS)
         coef_mem[TW'(req.tap_index)] <= req.tap_value;
      if (smp_fire) hist_mem[wp_ff] <= req.sample_in;
      rdata_ff <= hist_mem[raddr];
      rvalid_ff <= hvalid_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff <= '0;
         hvalid_ff <= '0;
      end else begin
         if (req_fire && req.command == CMD_COEF && 32'(req.tap_index) < MAX_HALF_TAPS)
            cvalid_ff[TW'(req.tap_index)] <= 1'b1;
         if (smp_fire) hvalid_ff[wp_ff] <= 1'b1;
      end
   end

   wire signed [SAMPLE_BITS-1:0] rd_val = rvalid_ff ? rdata_ff : '0;
   wire signed [AW-1:0] rnd = (acc_ff <<< 1) + (AW'(1) <<< (COEF_FRAC - 1));
   wire signed [AW-1:0] ysh = rnd >>> COEF_FRAC;
   wire signed [AW-1:0] smax = AW'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
   wire signed [AW-1:0] smin = -smax - AW'(1);

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      rd_in = rd_ff;
      case (state_ff)
         ST_IDLE: if (smp_fire) begin
            state_in = ST_FETCH;
            k_in = '0;
            rd_in = 2'd0;
         end
         ST_FETCH: begin
            // cycle through reads; rd 3 means both pair words registered
            if (rd_ff == 2'd1) rd_in = 2'd3;
            else if (rd_ff == 2'd3) state_in = ST_MAC;
            else rd_in = rd_ff + 2'd1;
         end
         ST_MAC: if (32'(bit_ff) == COEF_BITS - 1) state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (k_ff + 6'd1 == h_eff) begin
               state_in = ST_FINISH;
               rd_in = 2'd2;
            end else begin
               state_in = ST_FETCH;
               k_in = k_ff + 6'd1;
               rd_in = 2'd0;
            end
         end
         ST_FINISH: if (rd_ff == 2'd3) state_in = ST_OUT0; else rd_in = 2'd3;
         ST_OUT0: if (rsp.ready) state_in = ST_OUT1;
         ST_OUT1: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff <= '0;
         k_ff <= '0;
         rd_ff <= '0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         rd_ff <= rd_in;
         if (state_ff == ST_OUT1 && rsp.ready) wp_ff <= wp_ff + HW'(1);
      end
   end

   // bit-serial multiply: one coefficient bit per cycle, msb weighted negative
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: acc_ff <= '0;
         ST_FETCH: begin
            if (rd_ff == 2'd1) a_ff <= rd_val;
            if (rd_ff == 2'd3) begin
               pair_ff <= PW'(a_ff) + PW'(rd_val);
               cshift_ff <= cvalid_ff[TW'(k_ff)] ? coef_mem[TW'(k_ff)] : '0;
               bit_ff <= '0;
               prod_ff <= '0;
            end
         end
         ST_MAC: begin
            if (cshift_ff[0]) begin
               if (32'(bit_ff) == COEF_BITS - 1)
                  prod_ff <= prod_ff - ((PW+COEF_BITS)'(pair_ff) <<< bit_ff);
               else
                  prod_ff <= prod_ff + ((PW+COEF_BITS)'(pair_ff) <<< bit_ff);
            end
            cshift_ff <= cshift_ff >> 1;
            bit_ff <= bit_ff + BW'(1);
         end
         ST_ACCUM: acc_ff <= acc_ff + AW'(prod_ff);
         ST_FINISH: if (rd_ff == 2'd3) begin
            d_ff <= rd_val;
            if (ysh > smax) y_ff <= smax[SAMPLE_BITS-1:0];
            else if (ysh < smin) y_ff <= smin[SAMPLE_BITS-1:0];
            else y_ff <= ysh[SAMPLE_BITS-1:0];
         end
         default: ;
      endcase
   end

   assign rsp.valid = (state_ff == ST_OUT0) || (state_ff == ST_OUT1);
   assign rsp.sample_out = (state_ff == ST_OUT1) ? d_ff : y_ff;
   assign rsp.phase = (state_ff == ST_OUT1);
   assign rsp.last = (state_ff == ST_OUT1);

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("accept while busy");
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT0 && rsp.ready |=> state_ff == ST_OUT1)
      else $error("second result missing");
   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT1 && rsp.ready |=> wp_ff == $past(wp_ff) + HW'(1))
      else $error("pointer not advanced");
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> k_ff < h_eff) else $error("tap out of range");
endmodule
